>>> hw/rtl/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// shared types and constants for the double-ended queue
// ----------------------------------------------------------------------------
package dq_pkg;

    // ring depth, kept a power of two so that indices wrap by truncation
    localparam int DEPTH  = 1024;
    localparam int DATA_W = 16;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = ADDR_W + 1;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_count;
    typedef logic [DATA_W-1:0] t_data;

    localparam t_addr  ADDR_ONE  = t_addr'(1);
    localparam t_count CNT_ONE   = t_count'(1);
    localparam t_count CNT_FULL  = t_count'(DEPTH);

    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } t_dq_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_dq_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_OUT  = 1'b1
    } t_dq_state;

    // controller to datapath
    typedef struct packed {
        logic       load;     // word accepted this cycle
        logic       wr_en;    // push goes ahead
        logic       rd_en;    // pop goes ahead
        t_dq_op     op;
        t_dq_status status;
    } t_dq_cmd;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
    } t_dq_stat;

endpackage

>>> hw/rtl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// bounded double-ended queue of 1024 16-bit words held in a ring buffer
// ----------------------------------------------------------------------------
// timing: the result word is offered in the cycle after the input word is taken
// flow: a new word is taken only once the last result word has been taken,
//   set by the single-entry result register and the registered ram read
// reset: synchronous, active low; clears front index, count and handshake
//   state; ram contents stay undefined and are never read before written
// ----------------------------------------------------------------------------
module double_ended_queue
    import dq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input side
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] data_in
    input  logic [1:0]  s_axis_tuser,   // [1:0] op
    // result side
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] data_out, [26:16] occupancy, rest zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    t_dq_cmd  cmd;
    t_dq_stat stat;
    t_data    data_out;
    t_count   occ;

    // controller: accepts one word, decodes it against empty and full,
    // then holds the result until it is taken
    dq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_op        (s_axis_tuser),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // datapath: ring store with a registered read, pointer and count update
    dq_dpath u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_data   (s_axis_tdata[DATA_W-1:0]),
        .o_stat   (stat),
        .o_data   (data_out),
        .o_status (m_axis_tuser),
        .o_occ    (occ)
    );

    // pack the result word, padded to whole bytes
    assign m_axis_tdata = {{(32 - DATA_W - CNT_W){1'b0}}, occ, data_out};

endmodule

>>> hw/rtl/dq_ctrl.sv
// ----------------------------------------------------------------------------
// dq_ctrl
// handshake sequencer and operation decode for the queue
// ----------------------------------------------------------------------------
module dq_ctrl
    import dq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_op,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dq_stat   i_stat,
    output t_dq_cmd    o_cmd
);

    t_dq_state r_state;
    t_dq_state n_state;
    t_dq_op    op;

    assign op = t_dq_op'(i_op);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_out_valid  = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.wr_en  = 1'b0;
        o_cmd.rd_en  = 1'b0;
        o_cmd.op     = op;
        o_cmd.status = ST_OK;

        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (i_stat.full) begin
                    o_cmd.status = ST_FULL;
                end
            end
            default: begin
                if (i_stat.empty) begin
                    o_cmd.status = ST_EMPTY;
                end
            end
        endcase

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (o_cmd.status == ST_OK) begin
                        o_cmd.wr_en = (op == OP_PUSH_FRONT) || (op == OP_PUSH_BACK);
                        o_cmd.rd_en = (op == OP_POP_FRONT) || (op == OP_POP_BACK);
                    end
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> hw/rtl/dq_dpath.sv
// ----------------------------------------------------------------------------
// dq_dpath
// ring buffer store, front index and count for the queue
// ----------------------------------------------------------------------------
module dq_dpath
    import dq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dq_cmd     i_cmd,
    input  t_data       i_data,
    output t_dq_stat    o_stat,
    output t_data       o_data,
    output logic [1:0]  o_status,
    output t_count      o_occ
);

    t_data      mem [DEPTH];
    t_addr      r_front;
    t_addr      n_front;
    t_count     r_count;
    t_count     n_count;
    t_data      r_rd_data;
    logic       r_rd_ok;
    t_dq_status r_status;
    t_addr      addr;
    t_addr      cnt_lo;

    assign cnt_lo = r_count[ADDR_W-1:0];

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CNT_FULL);

    // entry touched by this operation
    always_comb begin
        case (i_cmd.op)
            OP_PUSH_FRONT: addr = r_front - ADDR_ONE;
            OP_PUSH_BACK:  addr = r_front + cnt_lo;
            OP_POP_FRONT:  addr = r_front;
            OP_POP_BACK:   addr = r_front + cnt_lo - ADDR_ONE;
            default:       addr = r_front;
        endcase
    end

    always_comb begin
        n_front = r_front;
        n_count = r_count;
        if (i_cmd.wr_en || i_cmd.rd_en) begin
            case (i_cmd.op)
                OP_PUSH_FRONT: begin
                    n_front = r_front - ADDR_ONE;
                    n_count = r_count + CNT_ONE;
                end
                OP_PUSH_BACK: begin
                    n_count = r_count + CNT_ONE;
                end
                OP_POP_FRONT: begin
                    n_front = r_front + ADDR_ONE;
                    n_count = r_count - CNT_ONE;
                end
                default: begin
                    n_count = r_count - CNT_ONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[addr] <= i_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front  <= '0;
            r_count  <= '0;
            r_rd_ok  <= 1'b0;
            r_status <= ST_OK;
        end else begin
            r_front <= n_front;
            r_count <= n_count;
            if (i_cmd.load) begin
                r_rd_ok  <= i_cmd.rd_en;
                r_status <= i_cmd.status;
            end
        end
    end

    assign o_data   = r_rd_ok ? r_rd_data : '0;
    assign o_status = r_status;
    assign o_occ    = r_count;

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the ring-buffer double-ended queue
// ----------------------------------------------------------------------------
// a local copy of the deque (ring, head index, fill level) predicts data,
// status and occupancy for every accepted word. directed words cover the
// empty and pop cases, pushes at random ends then fill the ring to full and
// push into it, and a short mixed tail works around the full mark. both
// sides idle at random, and the result side holds off once for a long stretch
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dq_pkg::*;

    localparam int TAIL_WORDS  = 16;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AFTER  = 200;

    // one pending input word and the gap the sender waits before it
    typedef struct {
        t_dq_op      op;
        t_data       data;
        int unsigned gap;
    } t_stim_word;

    // one predicted result word
    typedef struct {
        t_data      data;
        t_dq_status status;
        t_count     occ;
    } t_result_word;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;     // [15:0] data_in
    logic [1:0]  s_axis_tuser  = '0;     // [1:0] op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;           // [15:0] data_out, [26:16] occupancy, rest zero
    logic [1:0]  m_axis_tuser;           // [1:0] status

    // words still to be offered and results still to arrive
    t_stim_word   stim_words[$];
    t_result_word expected_results[$];

    // local copy of the deque
    t_data  model_ring[DEPTH];
    t_addr  model_head = '0;
    t_count model_fill = '0;

    // fill level tracked while the stimulus is built, used to plan the full pass
    int unsigned gen_fill = 0;

    logic        in_fire  = 1'b0;
    logic        out_fire = 1'b0;
    int          in_count    = 0;
    int          out_count   = 0;
    int          fail_count  = 0;
    int          total_words = 0;
    int unsigned cycle_count = 0;
    int unsigned tx_wait  = 0;
    int unsigned rx_stall = 0;
    logic        hold_off  = 1'b0;
    logic        hold_done = 1'b0;
    int unsigned hold_left = 0;

    double_ended_queue dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // queue one word with a freshly drawn gap
    task automatic add_word(input t_dq_op op, input t_data word);
        t_stim_word w;
        w.op   = op;
        w.data = word;
        w.gap  = $urandom_range(0, 19);
        stim_words.insert(stim_words.size(), w);
        if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) begin
            if (gen_fill < DEPTH)
                gen_fill++;
        end else if (gen_fill > 0) begin
            gen_fill--;
        end
    endtask

    // random push (either end) with the given chance in percent, else a pop
    task automatic add_random(input int push_pct);
        if ($urandom_range(0, 99) < push_pct)
            add_word($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT, t_data'($urandom));
        else
            add_word($urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT, t_data'($urandom));
    endtask

    // stimulus, reset and end of run
    initial begin
        // directed: pops on empty, data extremes, head wrap both ways
        add_word(OP_POP_FRONT,  16'hFFFF);
        add_word(OP_POP_BACK,   16'hFFFF);
        add_word(OP_PUSH_FRONT, 16'hFFFF);   // head wraps below zero
        add_word(OP_PUSH_BACK,  16'h0000);
        add_word(OP_PUSH_FRONT, 16'h0001);
        add_word(OP_PUSH_BACK,  16'h8000);
        add_word(OP_POP_BACK,   16'h0000);
        add_word(OP_POP_FRONT,  16'h0000);
        add_word(OP_POP_FRONT,  16'h1234);
        add_word(OP_POP_BACK,   16'h1234);
        add_word(OP_POP_BACK,   16'h0000);   // empty again
        add_word(OP_PUSH_BACK,  16'hAAAA);
        add_word(OP_PUSH_BACK,  16'h5555);
        add_word(OP_POP_FRONT,  16'h0000);   // head moves up from zero
        add_word(OP_PUSH_FRONT, 16'h1234);
        add_word(OP_POP_BACK,   16'hFFFF);
        add_word(OP_POP_BACK,   16'hFFFF);
        add_word(OP_POP_FRONT,  16'h0000);

        // fill to full with pushes at either end, then push into the full ring
        while (gen_fill < DEPTH)
            add_random(100);
        repeat (4) add_random(100);

        // short mixed tail around the full mark
        repeat (TAIL_WORDS) add_random(50);
        total_words = stim_words.size();

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (in_count < total_words)
            @(posedge i_clk);
        while (expected_results.size() != 0)
            @(posedge i_clk);
        // let any stray result word show up
        repeat (8) @(posedge i_clk);

        if (fail_count == 0 && expected_results.size() == 0)
            $display("[double_ended_queue] OK");
        else
            $display("[double_ended_queue] ERROR");
        $finish;
    end

    // sender: offers the next word once its gap has run out
    always @(negedge i_clk) begin : b_sender
        t_stim_word w;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_fire) begin
            if (stim_words.size() != 0 && tx_wait >= stim_words[0].gap) begin
                w = stim_words[0];
                stim_words.delete(0);
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= w.data;
                s_axis_tuser  <= w.op;
                tx_wait       <= 0;
            end else begin
                s_axis_tvalid <= 1'b0;
                tx_wait       <= tx_wait + 1;
            end
        end
    end

    // receiver: a fresh stall after every result word, none in quiet windows
    always @(negedge i_clk) begin : b_receiver
        int unsigned stall;
        stall = rx_stall;
        if (out_fire)
            stall = ((out_count % 300) < 80) ? 0 : $urandom_range(0, 19);
        else if (stall != 0)
            stall--;
        rx_stall      <= stall;
        m_axis_tready <= i_rst_n && (stall == 0) && !hold_off;
    end

    // one long hold-off on the result side so the block backs up its input
    always @(negedge i_clk) begin : b_hold
        if (!hold_done && !hold_off && in_count >= HOLD_AFTER) begin
            hold_off  <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end else if (hold_off) begin
            if (hold_left == 0) begin
                hold_off  <= 1'b0;
                hold_done <= 1'b1;
            end else begin
                hold_left <= hold_left - 1;
            end
        end
    end

    // checker first, then predictor, so a result can never match its own word
    always @(posedge i_clk) begin : b_monitor
        t_result_word want;
        t_result_word got;
        t_addr        slot;

        in_fire  <= i_rst_n && s_axis_tvalid && s_axis_tready;
        out_fire <= i_rst_n && m_axis_tvalid && m_axis_tready;

        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            out_count <= out_count + 1;
            if (expected_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result word %0d: tdata %h tuser %h",
                             out_count, m_axis_tdata, m_axis_tuser);
            end else begin
                want = expected_results[0];
                expected_results.delete(0);
                if (m_axis_tdata[15:0] !== want.data || m_axis_tdata[26:16] !== want.occ
                        || m_axis_tdata[31:27] !== '0 || m_axis_tuser !== want.status) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("mismatch on result %0d: expected data %h status %0d occupancy %0d",
                                 out_count, want.data, want.status, want.occ);
                        $display("  got data %h status %0d occupancy %0d pad %h",
                                 m_axis_tdata[15:0], m_axis_tuser, m_axis_tdata[26:16],
                                 m_axis_tdata[31:27]);
                    end
                end
            end
        end

        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            in_count   <= in_count + 1;
            got.data   = '0;
            got.status = ST_OK;
            case (t_dq_op'(s_axis_tuser))
                OP_PUSH_FRONT: begin
                    if (model_fill == CNT_FULL) begin
                        got.status = ST_FULL;
                    end else begin
                        // head steps back, wrapping below zero
                        model_head             = model_head - ADDR_ONE;
                        model_ring[model_head] = s_axis_tdata;
                        model_fill             = model_fill + CNT_ONE;
                    end
                end
                OP_PUSH_BACK: begin
                    if (model_fill == CNT_FULL) begin
                        got.status = ST_FULL;
                    end else begin
                        slot             = model_head + t_addr'(model_fill);
                        model_ring[slot] = s_axis_tdata;
                        model_fill       = model_fill + CNT_ONE;
                    end
                end
                OP_POP_FRONT: begin
                    if (model_fill == '0) begin
                        got.status = ST_EMPTY;
                    end else begin
                        got.data   = model_ring[model_head];
                        model_head = model_head + ADDR_ONE;
                        model_fill = model_fill - CNT_ONE;
                    end
                end
                default: begin
                    if (model_fill == '0) begin
                        got.status = ST_EMPTY;
                    end else begin
                        slot       = model_head + t_addr'(model_fill - CNT_ONE);
                        got.data   = model_ring[slot];
                        model_fill = model_fill - CNT_ONE;
                    end
                end
            endcase
            got.occ = model_fill;
            expected_results.insert(expected_results.size(), got);
        end
    end

    // watchdog against a hung handshake
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[double_ended_queue] ERROR");
            $finish;
        end
    end

endmodule
